FILE: sv/rbth_pkg.sv
package rbth_pkg;

	localparam int NUM_TRI    = 12;
	localparam int NUM_CORNER = 8;
	localparam int NUM_AXIS   = 3;
	// register stages from a cell's ray register to its hit output
	localparam int CELL_DEPTH = 8;

	typedef logic [2:0] corner_t;

	// bit 0: x from max, bit 1: y from max, bit 2: z from max
	localparam corner_t CORNER_SEL [NUM_CORNER] = '{
		3'd0, 3'd2, 3'd3, 3'd1, 3'd4, 3'd6, 3'd7, 3'd5
	};

	localparam corner_t TRI_IDX [NUM_TRI*3] = '{
		3'd0, 3'd1, 3'd2,  3'd2, 3'd3, 3'd0,  3'd0, 3'd4, 3'd5,  3'd5, 3'd1, 3'd0,
		3'd4, 3'd7, 3'd6,  3'd6, 3'd5, 3'd4,  3'd2, 3'd6, 3'd7,  3'd7, 3'd3, 3'd2,
		3'd3, 3'd7, 3'd4,  3'd4, 3'd0, 3'd3,  3'd1, 3'd5, 3'd6,  3'd6, 3'd2, 3'd1
	};

	typedef enum logic [2:0] {
		REG_MIN_X = 3'd0,
		REG_MIN_Y = 3'd1,
		REG_MIN_Z = 3'd2,
		REG_MAX_X = 3'd3,
		REG_MAX_Y = 3'd4,
		REG_MAX_Z = 3'd5
	} cfg_reg_t;

endpackage

FILE: sv/ray_box_triangle_hit_test.sv
// channel  dir  handshake             payload
// in       in   in_valid / in_stall   origin_x..z, dir_x..z
// out      out  out_valid / out_stall hit
// cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One ray enters per cycle while in_stall is low; each ray walks the row of twelve
// triangle cells, one cell a cycle while the pipeline is not halted.
// Reset restores the box to the unit cube and empties the pipeline.
// A two-beat output buffer parts the sides; the pipeline halts only when it is full.
// cfg_ready is always high.
module ray_box_triangle_hit_test import rbth_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [COORD_WIDTH-1:0] origin_x,
	input  logic [COORD_WIDTH-1:0] origin_y,
	input  logic [COORD_WIDTH-1:0] origin_z,
	input  logic [COORD_WIDTH-1:0] dir_x,
	input  logic [COORD_WIDTH-1:0] dir_y,
	input  logic [COORD_WIDTH-1:0] dir_z,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   hit,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data
);

	localparam int W   = COORD_WIDTH;
	localparam int LAT = NUM_TRI + CELL_DEPTH;
	localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

	logic signed [W-1:0] box_min_q [NUM_AXIS];
	logic signed [W-1:0] box_max_q [NUM_AXIS];

	logic signed [W-1:0] ray_o [NUM_TRI][NUM_AXIS];
	logic signed [W-1:0] ray_d [NUM_TRI][NUM_AXIS];
	logic                hit_c [NUM_TRI+1];

	logic [LAT-1:0] vld_q;
	logic           en, done, take;
	logic           out_valid_q, hit_q, skid_full_q, skid_hit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_AXIS; k++) begin
				box_min_q[k] <= '0;
				box_max_q[k] <= ONE;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_X: box_min_q[0] <= cfg_data;
				REG_MIN_Y: box_min_q[1] <= cfg_data;
				REG_MIN_Z: box_min_q[2] <= cfg_data;
				REG_MAX_X: box_max_q[0] <= cfg_data;
				REG_MAX_Y: box_max_q[1] <= cfg_data;
				REG_MAX_Z: box_max_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;
	assign done     = en && vld_q[LAT-1];
	assign take     = out_valid_q && !out_stall;

	assign ray_o[0][0] = origin_x;
	assign ray_o[0][1] = origin_y;
	assign ray_o[0][2] = origin_z;
	assign ray_d[0][0] = dir_x;
	assign ray_d[0][1] = dir_y;
	assign ray_d[0][2] = dir_z;
	assign hit_c[0]    = 1'b0;

	for (genvar i = 0; i < NUM_TRI; i++) begin : g_cell
		if (i < NUM_TRI - 1) begin : g_mid
			rbth_cell #(
				.W  (W),
				.CA (TRI_IDX[3*i]),
				.CB (TRI_IDX[3*i+1]),
				.CC (TRI_IDX[3*i+2])
			) u_cell (
				.clk       (clk),
				.en        (en),
				.mn        (box_min_q),
				.mx        (box_max_q),
				.ray_o_in  (ray_o[i]),
				.ray_d_in  (ray_d[i]),
				.ray_o_q   (ray_o[i+1]),
				.ray_d_q   (ray_d[i+1]),
				.hit_in    (hit_c[i]),
				.hit_out_q (hit_c[i+1])
			);
		end else begin : g_last
			rbth_cell #(
				.W  (W),
				.CA (TRI_IDX[3*i]),
				.CB (TRI_IDX[3*i+1]),
				.CC (TRI_IDX[3*i+2])
			) u_cell (
				.clk       (clk),
				.en        (en),
				.mn        (box_min_q),
				.mx        (box_max_q),
				.ray_o_in  (ray_o[i]),
				.ray_d_in  (ray_d[i]),
				.ray_o_q   (),
				.ray_d_q   (),
				.hit_in    (hit_c[i]),
				.hit_out_q (hit_c[i+1])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// a full skid buffer halts the row, so no beat finishes while it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			skid_full_q <= 1'b0;
			skid_hit_q  <= 1'b0;
		end else begin
			if (take && skid_full_q) begin
				hit_q       <= skid_hit_q;
				skid_full_q <= 1'b0;
			end else if (done) begin
				if (!out_valid_q || take) begin
					out_valid_q <= 1'b1;
					hit_q       <= hit_c[NUM_TRI];
				end else begin
					skid_full_q <= 1'b1;
					skid_hit_q  <= hit_c[NUM_TRI];
				end
			end else if (take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid beat held with empty output register");

	a_held_beat_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result beat dropped");

	a_overflow_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_valid_q && out_stall) |=> skid_full_q)
		else $error("finished beat not parked in skid buffer");

endmodule

FILE: sv/rbth_cell.sv
module rbth_cell import rbth_pkg::*; #(
	parameter int      W  = 32,
	parameter corner_t CA = 3'd0,
	parameter corner_t CB = 3'd1,
	parameter corner_t CC = 3'd2
) (
	input  logic                clk,
	input  logic                en,
	input  logic signed [W-1:0] mn        [NUM_AXIS],
	input  logic signed [W-1:0] mx        [NUM_AXIS],
	input  logic signed [W-1:0] ray_o_in  [NUM_AXIS],
	input  logic signed [W-1:0] ray_d_in  [NUM_AXIS],
	output logic signed [W-1:0] ray_o_q   [NUM_AXIS],
	output logic signed [W-1:0] ray_d_q   [NUM_AXIS],
	input  logic                hit_in,
	output logic                hit_out_q
);

	localparam int DW = W + 1;
	localparam int MW = 2*W + 2;
	localparam int PW = 2*W + 3;
	localparam int LW = 2*W + 2;
	localparam int HW = 2*W + 4;
	localparam int FW = 3*W + 4;
	localparam int SW = 3*W + 6;
	localparam int CW = SW + 1;

	function automatic logic signed [HW-1:0] pp_hi(input logic signed [PW-1:0] x,
		input logic signed [DW-1:0] y);
		logic signed [PW-W-1:0] xh;
		xh = x[PW-1:W];
		return HW'(xh) * HW'(y);
	endfunction

	function automatic logic signed [LW-1:0] pp_lo(input logic signed [PW-1:0] x,
		input logic signed [DW-1:0] y);
		logic signed [W:0] xl;
		xl = {1'b0, x[W-1:0]};
		return LW'(xl) * LW'(y);
	endfunction

	function automatic logic signed [FW-1:0] pp_join(input logic signed [HW-1:0] hi,
		input logic signed [LW-1:0] lo);
		return (FW'(hi) <<< W) + FW'(lo);
	endfunction

	logic signed [W-1:0]  v0 [NUM_AXIS];
	logic signed [W-1:0]  v1 [NUM_AXIS];
	logic signed [W-1:0]  v2 [NUM_AXIS];

	logic signed [DW-1:0] e1_s1 [NUM_AXIS], e2_s1 [NUM_AXIS], t_s1 [NUM_AXIS];
	logic signed [W-1:0]  d_s1  [NUM_AXIS];
	logic signed [MW-1:0] pa_s2 [NUM_AXIS], pb_s2 [NUM_AXIS];
	logic signed [MW-1:0] qa_s2 [NUM_AXIS], qb_s2 [NUM_AXIS];
	logic signed [DW-1:0] e1_s2 [NUM_AXIS], t_s2 [NUM_AXIS];
	logic signed [W-1:0]  d_s2  [NUM_AXIS];
	logic signed [PW-1:0] p_s3  [NUM_AXIS], q_s3 [NUM_AXIS];
	logic signed [DW-1:0] e1_s3 [NUM_AXIS], t_s3 [NUM_AXIS];
	logic signed [W-1:0]  d_s3  [NUM_AXIS];
	logic signed [HW-1:0] dh_s4 [NUM_AXIS], uh_s4 [NUM_AXIS], vh_s4 [NUM_AXIS];
	logic signed [LW-1:0] dl_s4 [NUM_AXIS], ul_s4 [NUM_AXIS], vl_s4 [NUM_AXIS];
	logic signed [FW-1:0] fd_s5 [NUM_AXIS], fu_s5 [NUM_AXIS], fv_s5 [NUM_AXIS];
	logic signed [SW-1:0] det_s6, u_s6, v_s6;
	logic signed [SW-1:0] det_s7, u_s7, v_s7;
	logic                 zero_s7;
	logic signed [CW-1:0] uv_sum;
	logic                 tri_hit;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_o_q <= ray_o_in;
			ray_d_q <= ray_d_in;
		end
	end

	for (genvar k = 0; k < NUM_AXIS; k++) begin : g_axis
		localparam int A = (k + 1) % NUM_AXIS;
		localparam int B = (k + 2) % NUM_AXIS;

		assign v0[k] = CORNER_SEL[CA][k] ? mx[k] : mn[k];
		assign v1[k] = CORNER_SEL[CB][k] ? mx[k] : mn[k];
		assign v2[k] = CORNER_SEL[CC][k] ? mx[k] : mn[k];

		always_ff @(posedge clk) begin
			if (en) begin
				e1_s1[k] <= DW'(v1[k]) - DW'(v0[k]);
				e2_s1[k] <= DW'(v2[k]) - DW'(v0[k]);
				t_s1[k]  <= DW'(ray_o_q[k]) - DW'(v0[k]);
				d_s1[k]  <= ray_d_q[k];

				// p = d x e2, q = t x e1
				pa_s2[k] <= MW'(d_s1[A]) * MW'(e2_s1[B]);
				pb_s2[k] <= MW'(d_s1[B]) * MW'(e2_s1[A]);
				qa_s2[k] <= MW'(t_s1[A]) * MW'(e1_s1[B]);
				qb_s2[k] <= MW'(t_s1[B]) * MW'(e1_s1[A]);
				e1_s2[k] <= e1_s1[k];
				t_s2[k]  <= t_s1[k];
				d_s2[k]  <= d_s1[k];

				p_s3[k]  <= PW'(pa_s2[k]) - PW'(pb_s2[k]);
				q_s3[k]  <= PW'(qa_s2[k]) - PW'(qb_s2[k]);
				e1_s3[k] <= e1_s2[k];
				t_s3[k]  <= t_s2[k];
				d_s3[k]  <= d_s2[k];

				// wide factor split in two halves, joined next stage
				dh_s4[k] <= pp_hi(p_s3[k], e1_s3[k]);
				dl_s4[k] <= pp_lo(p_s3[k], e1_s3[k]);
				uh_s4[k] <= pp_hi(p_s3[k], t_s3[k]);
				ul_s4[k] <= pp_lo(p_s3[k], t_s3[k]);
				vh_s4[k] <= pp_hi(q_s3[k], DW'(d_s3[k]));
				vl_s4[k] <= pp_lo(q_s3[k], DW'(d_s3[k]));

				fd_s5[k] <= pp_join(dh_s4[k], dl_s4[k]);
				fu_s5[k] <= pp_join(uh_s4[k], ul_s4[k]);
				fv_s5[k] <= pp_join(vh_s4[k], vl_s4[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s6 <= SW'(fd_s5[0]) + SW'(fd_s5[1]) + SW'(fd_s5[2]);
			u_s6   <= SW'(fu_s5[0]) + SW'(fu_s5[1]) + SW'(fu_s5[2]);
			v_s6   <= SW'(fv_s5[0]) + SW'(fv_s5[1]) + SW'(fv_s5[2]);

			// fold the determinant sign into the numerators
			zero_s7 <= (det_s6 == '0);
			det_s7  <= det_s6[SW-1] ? -det_s6 : det_s6;
			u_s7    <= det_s6[SW-1] ? -u_s6   : u_s6;
			v_s7    <= det_s6[SW-1] ? -v_s6   : v_s6;

			hit_out_q <= hit_in | tri_hit;
		end
	end

	always_comb begin
		uv_sum  = CW'(u_s7) + CW'(v_s7);
		tri_hit = !zero_s7 && !u_s7[SW-1] && !v_s7[SW-1] &&
			(u_s7 <= det_s7) && (v_s7 <= det_s7) && (uv_sum <= CW'(det_s7));
	end

endmodule

FILE: bench/tb_ray_box_triangle_hit_test.sv
`timescale 1ns / 100ps

module tb_ray_box_triangle_hit_test;
	import rbth_pkg::*;

	localparam int W = 32;
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;
	localparam logic [W-1:0] ONE  = 32'h0001_0000;
	localparam logic [W-1:0] HALF = 32'h0000_8000;
	localparam logic [W-1:0] FAR  = 32'hFFFB_0000; // -5.0
	localparam logic [W-1:0] OUT5 = 32'h0005_0000; // 5.0
	localparam logic [W-1:0] SMAX = 32'h7FFF_FFFF;
	localparam logic [W-1:0] SMIN = 32'h8000_0000;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [W-1:0] org [3];
		logic [W-1:0] dir [3];
		bit           known;
		bit           want;
	} ray_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [W-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic [W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [W-1:0] cfg_data = '0;

	logic [W-1:0] box_regs [6];
	bit hit_q [$];
	int errors = 0;
	bit quiet = 0;
	int stall_left = 0;

	always #1 clk = ~clk;

	ray_box_triangle_hit_test DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.out_valid(out_valid), .out_stall(out_stall), .hit(hit),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic wide_t sx(logic [W-1:0] v);
		return wide_t'(signed'(v));
	endfunction

	// division-free Moller-Trumbore on one triangle, exact in 128 bits
	function automatic bit tri_meets(wide_t o [3], wide_t d [3],
			wide_t a [3], wide_t b [3], wide_t c [3]);
		wide_t e1 [3], e2 [3], t [3], p [3], q [3];
		wide_t det, u, v;
		int i, j;
		for (int k = 0; k < 3; k++) begin
			e1[k] = b[k] - a[k];
			e2[k] = c[k] - a[k];
			t[k]  = o[k] - a[k];
		end
		for (int k = 0; k < 3; k++) begin
			i = (k + 1) % 3;
			j = (k + 2) % 3;
			p[k] = d[i] * e2[j] - d[j] * e2[i];
			q[k] = t[i] * e1[j] - t[j] * e1[i];
		end
		det = 0; u = 0; v = 0;
		for (int k = 0; k < 3; k++) begin
			det += p[k] * e1[k];
			u   += p[k] * t[k];
			v   += q[k] * d[k];
		end
		if (det == 0)
			return 0;
		if (det < 0) begin
			det = -det; u = -u; v = -v;
		end
		return u >= 0 && v >= 0 && u <= det && v <= det && u + v <= det;
	endfunction

	function automatic bit box_hit(logic [W-1:0] org [3], logic [W-1:0] dir [3]);
		wide_t o [3], d [3], c [NUM_CORNER][3];
		corner_t sel;
		for (int k = 0; k < 3; k++) begin
			o[k] = sx(org[k]);
			d[k] = sx(dir[k]);
		end
		for (int n = 0; n < NUM_CORNER; n++) begin
			sel = CORNER_SEL[n];
			for (int k = 0; k < 3; k++)
				c[n][k] = sel[k] ? sx(box_regs[3 + k]) : sx(box_regs[k]);
		end
		for (int n = 0; n < NUM_TRI; n++)
			if (tri_meets(o, d, c[TRI_IDX[3*n]], c[TRI_IDX[3*n+1]], c[TRI_IDX[3*n+2]]))
				return 1;
		return 0;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (hit_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: hit=%0b", hit);
			end else if (hit_q[0] !== hit) begin
				errors++;
				if (errors <= 10)
					$display("hit mismatch: expected %0b actual %0b", hit_q[0], hit);
				void'(hit_q.pop_front());
			end else
				void'(hit_q.pop_front());
		end
	end

	// receiver back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 16);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(logic [2:0] idx, logic [W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= REG_MAX_Z)
			box_regs[idx] = data;
	endtask

	task automatic send_ray(logic [W-1:0] org [3], logic [W-1:0] dir [3]);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		origin_x <= org[0]; origin_y <= org[1]; origin_z <= org[2];
		dir_x <= dir[0]; dir_y <= dir[1]; dir_z <= dir[2];
		do @(posedge clk); while (in_stall);
		hit_q.push_back(box_hit(org, dir));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (hit_q.size() != 0) @(posedge clk);
		repeat (NUM_TRI + CELL_DEPTH + 5) @(posedge clk);
	endtask

	function automatic ray_row_t mk(logic [W-1:0] ox, oy, oz, dx, dy, dz,
			bit known, bit want);
		ray_row_t r;
		r.org = '{ox, oy, oz};
		r.dir = '{dx, dy, dz};
		r.known = known;
		r.want = want;
		return r;
	endfunction

	function automatic logic [W-1:0] pick(logic [W-1:0] lo, logic [W-1:0] hi);
		longint a, b;
		a = longint'(sx(lo));
		b = longint'(sx(hi));
		if (a > b) begin
			longint s = a;
			a = b; b = s;
		end
		return W'(a + longint'($urandom_range(0, 1023)) * (b - a) / 1023);
	endfunction

	task automatic set_box(logic [W-1:0] mn [3], logic [W-1:0] mx [3]);
		drain();
		write_reg(REG_MIN_X, mn[0]);
		write_reg(REG_MIN_Y, mn[1]);
		write_reg(REG_MIN_Z, mn[2]);
		write_reg(REG_MAX_X, mx[0]);
		write_reg(REG_MAX_Y, mx[1]);
		write_reg(REG_MAX_Z, mx[2]);
		// writes past the last register must leave the box alone
		write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		ray_row_t rows [$];
		logic [W-1:0] org [3], dir [3], mn [3], mx [3], tgt;
		longint ofs;

		box_regs = '{32'd0, 32'd0, 32'd0, ONE, ONE, ONE};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back(mk(HALF, HALF, FAR, 0, 0, ONE, 1, 1));
		rows.push_back(mk(HALF, HALF, FAR, 0, 0, 0, 1, 0));
		rows.push_back(mk(OUT5, OUT5, OUT5, 0, 0, ONE, 1, 0));
		rows.push_back(mk(HALF, HALF, HALF, ONE, 0, 0, 1, 1));
		rows.push_back(mk(HALF, FAR, HALF, 0, ONE, 0, 1, 1));
		rows.push_back(mk(FAR, HALF, HALF, ONE, 0, 0, 1, 1));
		rows.push_back(mk(HALF, HALF, OUT5, 0, 0, SMIN, 1, 1));
		rows.push_back(mk(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, 0, 0));
		rows.push_back(mk(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, 0, 0));
		rows.push_back(mk('1, '1, '1, 1, 1, 1, 0, 0));
		rows.push_back(mk(0, 0, FAR, 0, 0, ONE, 0, 0));
		rows.push_back(mk(ONE, ONE, FAR, 0, 0, ONE, 0, 0));
		rows.push_back(mk(HALF, HALF, 0, ONE, 0, 0, 0, 0));
		rows.push_back(mk(FAR, FAR, FAR, ONE, ONE, ONE, 0, 0));
		rows.push_back(mk(SMAX, SMIN, 0, SMIN, SMAX, '1, 0, 0));

		foreach (rows[i]) begin
			send_ray(rows[i].org, rows[i].dir);
			if (rows[i].known && hit_q[$] !== rows[i].want) begin
				errors++;
				if (errors <= 10)
					$display("row %0d: hand value %0b, predicted %0b",
						i, rows[i].want, hit_q[$]);
			end
		end

		for (int ph = 0; ph < 7; ph++) begin
			unique case (ph)
				0: begin mn = '{0, 0, 0}; mx = '{ONE, ONE, ONE}; end
				1: begin
					foreach (mn[k]) begin
						mn[k] = W'(-int'($urandom_range(0, 1 << 20)));
						mx[k] = W'($urandom_range(1, 1 << 20));
					end
				end
				2: begin mn = '{SMIN, SMIN, SMIN}; mx = '{SMAX, SMAX, SMAX}; end
				3: begin mn = '{ONE, 0, OUT5}; mx = '{0, ONE, FAR}; end
				4: begin mn = '{0, 0, HALF}; mx = '{ONE, ONE, HALF}; end
				5: begin
					foreach (mn[k]) begin
						mn[k] = $urandom;
						mx[k] = $urandom;
					end
				end
				default: begin mn = '{FAR, 0, HALF}; mx = '{OUT5, ONE, ONE}; end
			endcase
			if (ph > 0)
				set_box(mn, mx);
			if (ph == 6)
				quiet = 1;
			for (int n = 0; n < 130; n++) begin
				if ($urandom_range(0, 9) < 6) begin
					// aim the line through a point inside the box
					foreach (org[k]) begin
						tgt = pick(mn[k], mx[k]);
						ofs = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
						org[k] = W'(longint'(sx(tgt)) + ofs);
						dir[k] = W'(-ofs);
					end
					if ($urandom_range(0, 15) == 0)
						dir[$urandom_range(0, 2)] = '0;
				end else begin
					foreach (org[k]) begin
						org[k] = $urandom;
						dir[k] = $urandom;
					end
				end
				send_ray(org, dir);
			end
		end

		drain();
		if (errors == 0 && hit_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
